// File: rtl/mse_pkg.sv
// shared types and constants of the mips subset execute unit
package mse_pkg;

    localparam int          DATA_WORDS_DEF = 1024;
    localparam logic [31:0] RESET_PC       = 32'h0040_0000;

    localparam int                    CFG_ADDR_W        = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_START_PC = 3'd0;

    localparam logic ACT_EXEC    = 1'b0;
    localparam logic ACT_PRELOAD = 1'b1;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_LINK = 5'd31;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    localparam logic [4:0] RT_BGEZ    = 5'h01;
    localparam logic [4:0] RT_BLTZAL  = 5'h10;
    localparam logic [4:0] RT_BGEZAL  = 5'h11;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_B,
        LD_H,
        LD_W,
        LD_BU,
        LD_HU
    } ld_kind_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_RD,
        MEM_WR
    } mem_op_t;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  wreg;
        logic [31:0] wval;
        ld_kind_t    ld;
        logic        st;
        logic [31:0] saddr;
        logic [31:0] sval;
        logic        halted;
        mem_op_t     mop;
        logic [29:0] mx;
        logic [31:0] mdata;
    } exec_t;

endpackage

// File: rtl/mips_subset_execute_unit.sv
// top level of the mips subset execute unit

// Takes one request per clock while req_stall is low: an instruction word to execute at
// the current pc, or a preload of one data store word. Five stages: register file read,
// execute, data store index, data store access, result. Register values are forwarded
// from later stages; a request that reads a register which a load one or two stages
// ahead is about to write waits in execute until the load reaches the result stage.
// After reset the data store is cleared one word per cycle, index zero to DATA_WORDS-1,
// during which requests are stalled (configuration writes are taken). Writing start_pc
// also loads the pc.
module mips_subset_execute_unit
    import mse_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  action,
    input  logic [31:0]           instr,
    input  logic [9:0]            preload_index,
    input  logic [31:0]           preload_word,

    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [31:0]           next_pc,
    output logic                  reg_written,
    output logic [4:0]            dest_reg,
    output logic [31:0]           dest_value,
    output logic                  store_done,
    output logic [31:0]           store_address,
    output logic [31:0]           store_value,
    output logic                  halted
);

    localparam int IDX_W = $clog2(DATA_WORDS);
    localparam int XW    = 30;
    localparam bit POW2  = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

    // configuration
    logic [31:0] start_pc_reg;
    logic        cfg_we;

    // pipeline control
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s2_mv, s3_mv, s4_mv, s5_mv;
    logic s2_free, s3_free, s4_free, s5_free;
    logic s2_hz;
    logic req_acc;

    // architectural state
    logic [31:0] pc_reg;
    logic        run_flag_reg;

    // stage 2 request
    logic        s2_action_reg;
    logic [31:0] s2_instr_reg;
    logic [9:0]  s2_pidx_reg;
    logic [31:0] s2_pword_reg;

    exec_t s2_res;
    exec_t s3_reg, s4_reg, s5_reg;
    logic  s2_sys;

    // register file
    logic [31:0] rf_mem [32];
    logic [31:0] rf_a_reg, rf_b_reg;
    logic [31:0] rf_vld_reg;
    logic        a_vld_reg, b_vld_reg, a_byp_reg, b_byp_reg;
    logic [31:0] byp_data_reg;
    logic [4:0]  rf_ra, rf_rb, rf_wa;
    logic        rf_we;
    logic [31:0] rf_wd;

    // data store
    logic [31:0]      dm_mem [DATA_WORDS];
    logic [31:0]      dm_rd_reg;
    logic             dm_we, dm_re;
    logic [IDX_W-1:0] dm_addr;
    logic [31:0]      dm_wdata;
    logic [IDX_W-1:0] s4_idx;
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    // execute operands
    logic [5:0]  s2_op, s2_fn;
    logic [4:0]  s2_rs, s2_rt, s2_rd, s2_sa;
    logic [15:0] s2_imm;
    logic [31:0] s2_simm, op_a, op_b, a_base, b_base;
    logic [31:0] pc4, btarget, jtarget, ea;
    logic [31:0] s5_val;

    // apb port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == CFG_ADDR_START_PC);
    assign prdata = (paddr == CFG_ADDR_START_PC) ? start_pc_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= RESET_PC;
        end
        else if (cfg_we)
        begin
            start_pc_reg <= pwdata;
        end
    end

    // stage movement
    assign s5_mv   = s5_valid_reg && !res_stall;
    assign s5_free = !s5_valid_reg || s5_mv;
    assign s4_mv   = s4_valid_reg && s5_free;
    assign s4_free = !s4_valid_reg || s4_mv;
    assign s3_mv   = s3_valid_reg && s4_free;
    assign s3_free = !s3_valid_reg || s3_mv;
    assign s2_mv   = s2_valid_reg && !s2_hz && s3_free;
    assign s2_free = !s2_valid_reg || s2_mv;

    assign req_stall = clr_busy_reg || !s2_free;
    assign req_acc   = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_valid_reg <= req_acc;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_mv;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_mv;
            end
            if (s5_free)
            begin
                s5_valid_reg <= s4_mv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s2_action_reg <= action;
            s2_instr_reg  <= instr;
            s2_pidx_reg   <= preload_index;
            s2_pword_reg  <= preload_word;
        end
        if (s2_mv)
        begin
            s3_reg <= s2_res;
        end
        if (s3_mv)
        begin
            s4_reg <= s3_reg;
        end
        if (s4_mv)
        begin
            s5_reg <= s4_reg;
        end
    end

    // pc and run flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= RESET_PC;
            run_flag_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= pwdata;
            end
            else if (s2_mv)
            begin
                pc_reg <= s2_res.npc;
            end
            if (s2_mv)
            begin
                run_flag_reg <= !s2_res.halted;
            end
        end
    end

    // register file, registered read ahead of execute
    assign rf_ra = s2_free ? instr[25:21] : s2_rs;
    assign rf_rb = s2_free ? instr[20:16] : s2_rt;
    assign rf_we = s5_mv && s5_reg.wr;
    assign rf_wa = s5_reg.wreg;
    assign rf_wd = s5_val;

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        rf_a_reg <= rf_mem[rf_ra];
        rf_b_reg <= rf_mem[rf_rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            a_byp_reg  <= 1'b0;
            b_byp_reg  <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_vld_reg[rf_wa] <= 1'b1;
            end
            a_vld_reg <= rf_vld_reg[rf_ra];
            b_vld_reg <= rf_vld_reg[rf_rb];
            a_byp_reg <= rf_we && (rf_wa == rf_ra);
            b_byp_reg <= rf_we && (rf_wa == rf_rb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            byp_data_reg <= rf_wd;
        end
    end

    // operand forwarding
    assign s2_op   = s2_instr_reg[31:26];
    assign s2_rs   = s2_instr_reg[25:21];
    assign s2_rt   = s2_instr_reg[20:16];
    assign s2_rd   = s2_instr_reg[15:11];
    assign s2_sa   = s2_instr_reg[10:6];
    assign s2_fn   = s2_instr_reg[5:0];
    assign s2_imm  = s2_instr_reg[15:0];
    assign s2_simm = {{16{s2_imm[15]}}, s2_imm};

    assign a_base = a_byp_reg ? byp_data_reg : (a_vld_reg ? rf_a_reg : 32'd0);
    assign b_base = b_byp_reg ? byp_data_reg : (b_vld_reg ? rf_b_reg : 32'd0);

    always_comb
    begin
        if (s3_valid_reg && s3_reg.wr && s3_reg.ld == LD_NONE && s3_reg.wreg == s2_rs)
        begin
            op_a = s3_reg.wval;
        end
        else if (s4_valid_reg && s4_reg.wr && s4_reg.ld == LD_NONE && s4_reg.wreg == s2_rs)
        begin
            op_a = s4_reg.wval;
        end
        else if (s5_valid_reg && s5_reg.wr && s5_reg.wreg == s2_rs)
        begin
            op_a = s5_val;
        end
        else
        begin
            op_a = a_base;
        end

        if (s3_valid_reg && s3_reg.wr && s3_reg.ld == LD_NONE && s3_reg.wreg == s2_rt)
        begin
            op_b = s3_reg.wval;
        end
        else if (s4_valid_reg && s4_reg.wr && s4_reg.ld == LD_NONE && s4_reg.wreg == s2_rt)
        begin
            op_b = s4_reg.wval;
        end
        else if (s5_valid_reg && s5_reg.wr && s5_reg.wreg == s2_rt)
        begin
            op_b = s5_val;
        end
        else
        begin
            op_b = b_base;
        end
    end

    // load-use interlock
    assign s2_hz = s2_valid_reg &&
                   ((s3_valid_reg && s3_reg.ld != LD_NONE &&
                     (s3_reg.wreg == s2_rs || s3_reg.wreg == s2_rt)) ||
                    (s4_valid_reg && s4_reg.ld != LD_NONE &&
                     (s4_reg.wreg == s2_rs || s4_reg.wreg == s2_rt)));

    // execute
    assign pc4     = pc_reg + 32'd4;
    assign btarget = pc_reg + {s2_simm[29:0], 2'b00};
    assign jtarget = {pc4[31:28], s2_instr_reg[25:0], 2'b00};
    assign ea      = op_a + s2_simm;

    always_comb
    begin
        s2_res      = '0;
        s2_res.npc  = pc4;
        s2_res.ld   = LD_NONE;
        s2_res.mop  = MEM_NONE;
        s2_res.mx   = ea[31:2];
        s2_sys      = 1'b0;

        if (s2_action_reg == ACT_PRELOAD)
        begin
            s2_res.npc   = pc_reg;
            s2_res.mop   = MEM_WR;
            s2_res.mx    = XW'(s2_pidx_reg);
            s2_res.mdata = s2_pword_reg;
        end
        else if (!run_flag_reg)
        begin
            s2_res.npc = pc_reg;
        end
        else
        begin
            case (s2_op)
                OP_SPECIAL:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = s2_rd;
                    case (s2_fn)
                        FN_SLL:           s2_res.wval = op_b << s2_sa;
                        FN_SRL:           s2_res.wval = op_b >> s2_sa;
                        FN_SRA:           s2_res.wval = $unsigned($signed(op_b) >>> s2_sa);
                        FN_SLLV:          s2_res.wval = op_b << op_a[4:0];
                        FN_SRLV:          s2_res.wval = op_b >> op_a[4:0];
                        FN_SRAV:          s2_res.wval = $unsigned($signed(op_b) >>> op_a[4:0]);
                        FN_JR:
                        begin
                            s2_res.wr  = 1'b0;
                            s2_res.npc = op_a;
                        end
                        FN_SYSCALL:
                        begin
                            s2_res.wr = 1'b0;
                            s2_sys    = 1'b1;
                        end
                        FN_ADD, FN_ADDU:  s2_res.wval = op_a + op_b;
                        FN_SUB, FN_SUBU:  s2_res.wval = op_a - op_b;
                        FN_AND:           s2_res.wval = op_a & op_b;
                        FN_OR:            s2_res.wval = op_a | op_b;
                        FN_XOR:           s2_res.wval = op_a ^ op_b;
                        FN_SLT:           s2_res.wval = {31'd0, $signed(op_a) < $signed(op_b)};
                        FN_SLTU:          s2_res.wval = {31'd0, op_a < op_b};
                        default:          s2_res.wr = 1'b0;
                    endcase
                end
                OP_REGIMM:
                begin
                    if (s2_rt == RT_BGEZ)
                    begin
                        if (!op_a[31])
                        begin
                            s2_res.npc = btarget;
                        end
                    end
                    else if (s2_rt inside {RT_BLTZAL, RT_BGEZAL})
                    begin
                        s2_res.wr   = 1'b1;
                        s2_res.wreg = REG_LINK;
                        s2_res.wval = pc4;
                        if (s2_rt[0] ^ op_a[31])
                        begin
                            s2_res.npc = btarget;
                        end
                    end
                end
                OP_J:
                begin
                    s2_res.npc = jtarget;
                end
                OP_JAL:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = REG_LINK;
                    s2_res.wval = pc4;
                    s2_res.npc  = jtarget;
                end
                OP_BEQ:
                begin
                    if (op_a == op_b)
                    begin
                        s2_res.npc = btarget;
                    end
                end
                OP_BNE:
                begin
                    if (op_a != op_b)
                    begin
                        s2_res.npc = btarget;
                    end
                end
                OP_BLEZ:
                begin
                    if (op_a[31] || op_a == 32'd0)
                    begin
                        s2_res.npc = btarget;
                    end
                end
                OP_BGTZ:
                begin
                    if (!op_a[31] && op_a != 32'd0)
                    begin
                        s2_res.npc = btarget;
                    end
                end
                OP_ADDI, OP_ADDIU:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = s2_rt;
                    s2_res.wval = ea;
                end
                OP_ANDI:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = s2_rt;
                    s2_res.wval = op_a & {16'd0, s2_imm};
                end
                OP_ORI:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = s2_rt;
                    s2_res.wval = op_a | {16'd0, s2_imm};
                end
                OP_XORI:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = s2_rt;
                    s2_res.wval = op_a ^ {16'd0, s2_imm};
                end
                OP_LUI:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = s2_rt;
                    s2_res.wval = {s2_imm, 16'd0};
                end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                begin
                    s2_res.wr   = 1'b1;
                    s2_res.wreg = s2_rt;
                    s2_res.mop  = MEM_RD;
                    case (s2_op)
                        OP_LB:   s2_res.ld = LD_B;
                        OP_LH:   s2_res.ld = LD_H;
                        OP_LBU:  s2_res.ld = LD_BU;
                        OP_LHU:  s2_res.ld = LD_HU;
                        default: s2_res.ld = LD_W;
                    endcase
                end
                OP_SB, OP_SH, OP_SW:
                begin
                    s2_res.st    = 1'b1;
                    s2_res.saddr = ea;
                    s2_res.mop   = MEM_WR;
                    case (s2_op)
                        OP_SB:   s2_res.sval = {24'd0, op_b[7:0]};
                        OP_SH:   s2_res.sval = {16'd0, op_b[15:0]};
                        default: s2_res.sval = op_b;
                    endcase
                    s2_res.mdata = s2_res.sval;
                end
                default:
                begin
                    s2_res.wr = 1'b0;
                end
            endcase
        end

        // r0 stays zero
        if (s2_res.wr && s2_res.wreg == REG_ZERO)
        begin
            s2_res.wr  = 1'b0;
            s2_res.ld  = LD_NONE;
            s2_res.mop = MEM_NONE;
        end
        if (!s2_res.wr)
        begin
            s2_res.wreg = REG_ZERO;
            s2_res.wval = 32'd0;
        end
        s2_res.halted = !run_flag_reg || s2_sys;
    end

    // data store word index, taken modulo the store depth
    generate
        if (POW2)
        begin : g_idx_mask
            assign s4_idx = s4_reg.mx[IDX_W-1:0];
        end
        else
        begin : g_idx_recip
            localparam int               RSH   = XW + IDX_W;
            localparam int               QW    = XW - IDX_W + 1;
            localparam logic [XW:0]      RECIP = (XW + 1)'(((64'd1 << RSH) / DATA_WORDS) + 64'd1);
            localparam logic [IDX_W-1:0] DEPTH = IDX_W'(DATA_WORDS);

            logic [2*XW:0]   prod;
            logic [QW-1:0]   q_reg;
            logic [XW-1:0]   rem;

            assign prod = s3_reg.mx * RECIP;

            always_ff @(posedge clk)
            begin
                if (s3_mv)
                begin
                    q_reg <= prod[RSH +: QW];
                end
            end

            assign rem    = s4_reg.mx - XW'(q_reg) * XW'(DEPTH);
            assign s4_idx = rem[IDX_W-1:0];
        end
    endgenerate

    // data store, cleared after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == IDX_W'(DATA_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    assign dm_we    = clr_busy_reg || (s4_mv && s4_reg.mop == MEM_WR);
    assign dm_re    = s4_mv && s4_reg.mop == MEM_RD;
    assign dm_addr  = clr_busy_reg ? clr_idx_reg : s4_idx;
    assign dm_wdata = clr_busy_reg ? 32'd0 : s4_reg.mdata;

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_addr] <= dm_wdata;
        end
        if (dm_re)
        begin
            dm_rd_reg <= dm_mem[dm_addr];
        end
    end

    // result
    always_comb
    begin
        case (s5_reg.ld)
            LD_B:    s5_val = {{24{dm_rd_reg[7]}}, dm_rd_reg[7:0]};
            LD_H:    s5_val = {{16{dm_rd_reg[15]}}, dm_rd_reg[15:0]};
            LD_W:    s5_val = dm_rd_reg;
            LD_BU:   s5_val = {24'd0, dm_rd_reg[7:0]};
            LD_HU:   s5_val = {16'd0, dm_rd_reg[15:0]};
            default: s5_val = s5_reg.wval;
        endcase
    end

    assign res_valid     = s5_valid_reg;
    assign next_pc       = s5_reg.npc;
    assign reg_written   = s5_reg.wr;
    assign dest_reg      = s5_reg.wreg;
    assign dest_value    = s5_val;
    assign store_done    = s5_reg.st;
    assign store_address = s5_reg.saddr;
    assign store_value   = s5_reg.sval;
    assign halted        = s5_reg.halted;

`ifndef SYNTHESIS
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s2_valid_reg && !s3_valid_reg && !s4_valid_reg)
        else $error("pipeline busy during data store clear");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !run_flag_reg |=> !run_flag_reg)
        else $error("run flag set again after halt");

    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> rf_wa != REG_ZERO)
        else $error("register zero written");

    a_load_not_store: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && s5_reg.ld != LD_NONE |-> !s5_reg.st && s5_reg.wr)
        else $error("load result also marked as store");
`endif

endmodule
